// ----- rtl/led_cli_pkg.sv -----
package led_cli_pkg;

    localparam int LCL_MAX_LINE = 31;

    localparam logic [15:0] RST_NORMAL_TRANSITION = 16'd700;
    localparam logic [7:0]  RST_INSTANT_LOW       = 8'd9;
    localparam logic [7:0]  RST_INSTANT_HIGH      = 8'd12;
    localparam logic [15:0] RST_STROBE_INTERVAL   = 16'd85;
    localparam logic [7:0]  RST_SPEED_MIN         = 8'd64;
    localparam logic [7:0]  RST_SPEED_MAX         = 8'd191;
    localparam logic [7:0]  RST_PALETTE_MAX       = 8'd71;

    localparam logic [7:0] RST_CUSTOM_ONE   = 8'd128;
    localparam logic [7:0] RST_CUSTOM_TWO   = 8'd128;
    localparam logic [4:0] RST_CUSTOM_THREE = 5'd16;
    localparam logic [7:0] RST_INTENSITY    = 8'd128;
    localparam logic [7:0] RST_SPEED        = 8'd128;
    localparam logic [7:0] RST_PALETTE      = 8'd0;

    localparam logic [7:0] CUSTOM_THREE_MAX = 8'd31;
    localparam logic [7:0] PARAM_MAX        = 8'd255;
    localparam int         PRESET_MAX       = 250;

    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_NORMAL_TRANSITION = 3'd0;
    localparam t_cfg_index CFG_INSTANT_LOW       = 3'd1;
    localparam t_cfg_index CFG_INSTANT_HIGH      = 3'd2;
    localparam t_cfg_index CFG_STROBE_INTERVAL   = 3'd3;
    localparam t_cfg_index CFG_SPEED_MIN         = 3'd4;
    localparam t_cfg_index CFG_SPEED_MAX         = 3'd5;
    localparam t_cfg_index CFG_PALETTE_MAX       = 3'd6;

    typedef logic [3:0] t_action;
    localparam t_action ACT_PRESET        = 4'd0;
    localparam t_action ACT_POWER         = 4'd1;
    localparam t_action ACT_STROBE_BRIGHT = 4'd2;
    localparam t_action ACT_STROBE_DARK   = 4'd3;
    localparam t_action ACT_CUSTOM_ONE    = 4'd4;
    localparam t_action ACT_CUSTOM_TWO    = 4'd5;
    localparam t_action ACT_CUSTOM_THREE  = 4'd6;
    localparam t_action ACT_INTENSITY     = 4'd7;
    localparam t_action ACT_SPEED         = 4'd8;
    localparam t_action ACT_PALETTE       = 4'd9;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'd32;

    typedef logic [2:0] t_phase;
    localparam t_phase PH_LEAD   = 3'd0;
    localparam t_phase PH_TYPE   = 3'd1;
    localparam t_phase PH_DEAD   = 3'd2;
    localparam t_phase PH_VBLANK = 3'd3;
    localparam t_phase PH_VSIGN  = 3'd4;
    localparam t_phase PH_VDIGIT = 3'd5;
    localparam t_phase PH_VEND   = 3'd6;

    typedef logic [2:0][7:0] t_type_text;
    typedef logic [2:0] t_type_len;

    typedef logic [3:0] t_token;
    localparam t_token TK_P    = 4'd0;
    localparam t_token TK_PWR  = 4'd1;
    localparam t_token TK_STB  = 4'd2;
    localparam t_token TK_PAL  = 4'd3;
    localparam t_token TK_C1D  = 4'd4;
    localparam t_token TK_C2D  = 4'd5;
    localparam t_token TK_C3D  = 4'd6;
    localparam t_token TK_IXD  = 4'd7;
    localparam t_token TK_SXD  = 4'd8;
    localparam t_token TK_C1   = 4'd9;
    localparam t_token TK_C2   = 4'd10;
    localparam t_token TK_C3   = 4'd11;
    localparam t_token TK_IX   = 4'd12;
    localparam t_token TK_SX   = 4'd13;
    localparam t_token TK_NONE = 4'd15;

    localparam int TOKEN_COUNT = 14;

    localparam logic [23:0] TOKEN_TEXT [TOKEN_COUNT] = '{
        24'("P"), 24'("PWR"), 24'("STB"), 24'("PAL"), 24'("C1D"), 24'("C2D"), 24'("C3D"),
        24'("IXD"), 24'("SXD"), 24'("C1"), 24'("C2"), 24'("C3"), 24'("IX"), 24'("SX")
    };

    localparam t_type_len TOKEN_LEN [TOKEN_COUNT] = '{
        3'd1, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
    };

    function automatic logic is_blank(logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) ||
               (c == CHAR_FF) || (c == CHAR_CR);
    endfunction

    // type text left aligned and zero padded, tokens padded the same way
    function automatic t_token token_code(t_type_text txt, t_type_len len);
        logic [23:0] s;
        logic [23:0] want;
        t_token code;
        code = TK_NONE;
        case (len)
            3'd1:    s = {txt[0], 16'h0000};
            3'd2:    s = {txt[0], txt[1], 8'h00};
            3'd3:    s = {txt[0], txt[1], txt[2]};
            default: s = 24'h000000;
        endcase
        for (int k = TOKEN_COUNT - 1; k >= 0; k--) begin
            want = TOKEN_TEXT[k] << (5'd8 * (3'd3 - TOKEN_LEN[k]));
            if (len != 3'd0 && len <= 3'd3 && s == want) begin
                code = t_token'(k);
            end
        end
        return code;
    endfunction

    // lower bound tested first
    function automatic logic [7:0] clamp_val(logic signed [18:0] x, logic [7:0] lo,
                                             logic [7:0] hi);
        logic signed [18:0] slo;
        logic signed [18:0] shi;
        slo = $signed({11'd0, lo});
        shi = $signed({11'd0, hi});
        if (x < slo) begin
            return lo;
        end else if (x > shi) begin
            return hi;
        end
        return x[7:0];
    endfunction

endpackage

// ----- rtl/led_command_line_interpreter.sv -----
// Line-based LED command interpreter. Each input beat is a serial byte (command 0) or a
// one millisecond tick (command 1). Bytes build a line of up to MAX_LINE characters; an LF
// parses "TYPE:value" and may produce one result beat (preset, power toggle, strobe start or
// stop, or a changed effect parameter). Ticks advance the strobe timer while the strobe runs.
// A beat is registered on entry, then decoded and applied to the line and parameter state
// when the output register is free or being drained, and the result is held in that output
// register; a new beat is taken every cycle while the output side keeps up, so throughput is
// one beat per cycle, and a result is valid once it has passed the input and result registers.
// Configuration writes are meant to be made only while the block is idle.
module led_command_line_interpreter #(
    parameter int MAX_LINE = led_cli_pkg::LCL_MAX_LINE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_action,
    output logic [7:0]  o_action_value,
    output logic [15:0] o_transition_ms
);
    import led_cli_pkg::*;

    localparam int LW = $clog2(MAX_LINE + 1);

    logic [15:0] r_normal_transition;
    logic [7:0]  r_instant_low;
    logic [7:0]  r_instant_high;
    logic [15:0] r_strobe_interval;
    logic [7:0]  r_speed_min;
    logic [7:0]  r_speed_max;
    logic [7:0]  r_palette_max;

    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;

    logic [LW-1:0] r_len, n_len;
    t_phase        r_phase, n_phase;
    t_type_text    r_txt, n_txt;
    t_type_len     r_tlen, n_tlen;
    logic [15:0]   r_acc, n_acc;
    logic          r_neg, n_neg;
    logic [7:0]    r_c1, n_c1;
    logic [7:0]    r_c2, n_c2;
    logic [4:0]    r_c3, n_c3;
    logic [7:0]    r_intensity, n_intensity;
    logic [7:0]    r_speed, n_speed;
    logic [7:0]    r_palette, n_palette;
    logic          r_strobe_on, n_strobe_on;
    logic          r_bright, n_bright;
    logic [15:0]   r_elapsed, n_elapsed;

    logic          r_out_valid;
    t_action       r_action;
    logic [7:0]    r_value;
    logic [15:0]   r_trans;

    logic          n_emit;
    t_action       n_action;
    logic [7:0]    n_value;
    logic [15:0]   n_trans;

    logic          s_adv;

    assign s_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || s_adv;

    assign o_valid         = r_out_valid;
    assign o_action        = r_action;
    assign o_action_value  = r_value;
    assign o_transition_ms = r_trans;

    always_comb begin
        logic [7:0]         c;
        logic               digit;
        logic [3:0]         dval;
        logic [7:0]         ucase;
        logic [19:0]        acc_wide;
        logic [15:0]        acc_sat;
        logic [15:0]        elapsed_inc;
        logic [17:0]        v_mag;
        logic signed [17:0] v;
        logic signed [18:0] v_wide;
        logic signed [18:0] sum;
        t_token             code;
        logic [7:0]         cur;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [7:0]         next_val;
        logic [7:0]         pal_next;
        t_action            pact;

        n_len       = r_len;
        n_phase     = r_phase;
        n_txt       = r_txt;
        n_tlen      = r_tlen;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_c3        = r_c3;
        n_intensity = r_intensity;
        n_speed     = r_speed;
        n_palette   = r_palette;
        n_strobe_on = r_strobe_on;
        n_bright    = r_bright;
        n_elapsed   = r_elapsed;
        n_emit      = 1'b0;
        n_action    = ACT_PRESET;
        n_value     = 8'd0;
        n_trans     = 16'd0;

        c        = r_in_byte;
        digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        dval     = 4'(c - CHAR_ZERO);
        ucase    = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? (c - CASE_SHIFT) : c;
        acc_wide = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {16'd0, dval};
        acc_sat  = (acc_wide[19:16] != 4'd0) ? 16'hFFFF : acc_wide[15:0];

        elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : (r_elapsed + 16'd1);

        v_mag  = {2'b00, r_acc};
        v      = r_neg ? $signed(18'd0 - v_mag) : $signed(v_mag);
        v_wide = {v[17], v};
        code   = token_code(r_txt, r_tlen);

        // parameter path for the delta and absolute forms
        cur  = r_speed;
        lo   = r_speed_min;
        hi   = r_speed_max;
        pact = ACT_SPEED;
        case (code) inside
            TK_C1D, TK_C1: begin
                cur = r_c1; lo = 8'd0; hi = PARAM_MAX; pact = ACT_CUSTOM_ONE;
            end
            TK_C2D, TK_C2: begin
                cur = r_c2; lo = 8'd0; hi = PARAM_MAX; pact = ACT_CUSTOM_TWO;
            end
            TK_C3D, TK_C3: begin
                cur = {3'b000, r_c3}; lo = 8'd0; hi = CUSTOM_THREE_MAX;
                pact = ACT_CUSTOM_THREE;
            end
            TK_IXD, TK_IX: begin
                cur = r_intensity; lo = 8'd0; hi = PARAM_MAX; pact = ACT_INTENSITY;
            end
            default: begin
                cur = r_speed; lo = r_speed_min; hi = r_speed_max; pact = ACT_SPEED;
            end
        endcase
        sum      = ((code >= TK_C1D && code <= TK_SXD) ? $signed({11'd0, cur}) : 19'sd0)
                   + v_wide;
        next_val = clamp_val(sum, lo, hi);
        pal_next = clamp_val(v_wide, 8'd0, r_palette_max);

        if (r_in_cmd) begin
            if (r_strobe_on) begin
                if (elapsed_inc >= r_strobe_interval) begin
                    n_elapsed = 16'd0;
                    n_bright  = !r_bright;
                    n_emit    = 1'b1;
                    n_action  = r_bright ? ACT_STROBE_DARK : ACT_STROBE_BRIGHT;
                end else begin
                    n_elapsed = elapsed_inc;
                end
            end
        end else if (c == CHAR_LF) begin
            if (r_len != '0) begin
                n_len   = '0;
                n_phase = PH_LEAD;
                n_tlen  = 3'd0;
                n_acc   = 16'd0;
                n_neg   = 1'b0;
                if (r_phase >= PH_VBLANK && code != TK_NONE) begin
                    case (code) inside
                        TK_P: begin
                            if (v >= 18'sd1 && v <= 18'(PRESET_MAX)) begin
                                n_emit   = 1'b1;
                                n_action = ACT_PRESET;
                                n_value  = v[7:0];
                                n_trans  = (v[7:0] >= r_instant_low &&
                                            v[7:0] <= r_instant_high) ? 16'd0
                                                                      : r_normal_transition;
                            end
                        end
                        TK_PWR: begin
                            n_emit   = 1'b1;
                            n_action = ACT_POWER;
                        end
                        TK_STB: begin
                            if (v == 18'sd1) begin
                                if (!r_strobe_on) begin
                                    n_strobe_on = 1'b1;
                                    n_bright    = 1'b1;
                                    n_elapsed   = 16'd0;
                                    n_emit      = 1'b1;
                                    n_action    = ACT_STROBE_BRIGHT;
                                end
                            end else if (r_strobe_on) begin
                                n_strobe_on = 1'b0;
                                n_emit      = 1'b1;
                                n_action    = ACT_STROBE_BRIGHT;
                            end
                        end
                        TK_PAL: begin
                            if (pal_next != r_palette) begin
                                n_palette = pal_next;
                                n_emit    = 1'b1;
                                n_action  = ACT_PALETTE;
                                n_value   = pal_next;
                            end
                        end
                        default: begin
                            if (next_val != cur) begin
                                n_emit   = 1'b1;
                                n_action = pact;
                                n_value  = next_val;
                                case (pact)
                                    ACT_CUSTOM_ONE:   n_c1        = next_val;
                                    ACT_CUSTOM_TWO:   n_c2        = next_val;
                                    ACT_CUSTOM_THREE: n_c3        = next_val[4:0];
                                    ACT_INTENSITY:    n_intensity = next_val;
                                    default:          n_speed     = next_val;
                                endcase
                            end
                        end
                    endcase
                end
            end
        end else if (c != CHAR_CR) begin
            if (r_len < LW'(MAX_LINE)) begin
                n_len = r_len + LW'(1);
                unique case (r_phase) inside
                    PH_LEAD: begin
                        if (!is_blank(c)) begin
                            if (c == CHAR_COLON) begin
                                n_phase = PH_DEAD;
                            end else begin
                                if (r_tlen < 3'd3) n_txt[r_tlen[1:0]] = ucase;
                                if (r_tlen < 3'd4) n_tlen = r_tlen + 3'd1;
                                n_phase = PH_TYPE;
                            end
                        end
                    end
                    PH_TYPE: begin
                        if (c == CHAR_COLON) begin
                            n_phase = PH_VBLANK;
                        end else begin
                            if (r_tlen < 3'd3) n_txt[r_tlen[1:0]] = ucase;
                            if (r_tlen < 3'd4) n_tlen = r_tlen + 3'd1;
                        end
                    end
                    PH_VBLANK: begin
                        if (!is_blank(c)) begin
                            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                                n_neg   = (c == CHAR_MINUS);
                                n_phase = PH_VSIGN;
                            end else if (digit) begin
                                n_acc   = {12'd0, dval};
                                n_phase = PH_VDIGIT;
                            end else begin
                                n_phase = PH_VEND;
                            end
                        end
                    end
                    PH_VSIGN, PH_VDIGIT: begin
                        if (digit) begin
                            n_acc   = acc_sat;
                            n_phase = PH_VDIGIT;
                        end else begin
                            n_phase = PH_VEND;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_len   = '0;
                n_phase = PH_LEAD;
                n_tlen  = 3'd0;
                n_acc   = 16'd0;
                n_neg   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_transition <= RST_NORMAL_TRANSITION;
            r_instant_low       <= RST_INSTANT_LOW;
            r_instant_high      <= RST_INSTANT_HIGH;
            r_strobe_interval   <= RST_STROBE_INTERVAL;
            r_speed_min         <= RST_SPEED_MIN;
            r_speed_max         <= RST_SPEED_MAX;
            r_palette_max       <= RST_PALETTE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NORMAL_TRANSITION: r_normal_transition <= i_cfg_data;
                CFG_INSTANT_LOW:       r_instant_low       <= i_cfg_data[7:0];
                CFG_INSTANT_HIGH:      r_instant_high      <= i_cfg_data[7:0];
                CFG_STROBE_INTERVAL:   r_strobe_interval   <= i_cfg_data;
                CFG_SPEED_MIN:         r_speed_min         <= i_cfg_data[7:0];
                CFG_SPEED_MAX:         r_speed_max         <= i_cfg_data[7:0];
                CFG_PALETTE_MAX:       r_palette_max       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd  <= i_command;
            r_in_byte <= i_data_byte;
        end
    end

    // line and parameter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_phase     <= PH_LEAD;
            r_txt       <= '0;
            r_tlen      <= 3'd0;
            r_acc       <= 16'd0;
            r_neg       <= 1'b0;
            r_c1        <= RST_CUSTOM_ONE;
            r_c2        <= RST_CUSTOM_TWO;
            r_c3        <= RST_CUSTOM_THREE;
            r_intensity <= RST_INTENSITY;
            r_speed     <= RST_SPEED;
            r_palette   <= RST_PALETTE;
            r_strobe_on <= 1'b0;
            r_bright    <= 1'b1;
            r_elapsed   <= 16'd0;
        end else if (s_adv) begin
            r_len       <= n_len;
            r_phase     <= n_phase;
            r_txt       <= n_txt;
            r_tlen      <= n_tlen;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_c1        <= n_c1;
            r_c2        <= n_c2;
            r_c3        <= n_c3;
            r_intensity <= n_intensity;
            r_speed     <= n_speed;
            r_palette   <= n_palette;
            r_strobe_on <= n_strobe_on;
            r_bright    <= n_bright;
            r_elapsed   <= n_elapsed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= n_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && n_emit) begin
            r_action <= n_action;
            r_value  <= n_value;
            r_trans  <= n_trans;
        end
    end

endmodule

// ----- bench/led_cli_checker.sv -----
`timescale 1ns / 100ps

module led_cli_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_tick,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_action,
    input  logic [7:0]  i_action_value,
    input  logic [15:0] i_transition_ms,
    output int          o_pending,
    output int          o_fails
);
    import led_cli_pkg::*;

    typedef struct packed {
        t_action     act;
        logic [7:0]  value;
        logic [15:0] trans;
    } t_led_action;

    t_led_action expected_actions[$];

    logic [15:0] normal_trans;
    logic [7:0]  instant_lo;
    logic [7:0]  instant_hi;
    logic [15:0] strobe_period;
    logic [7:0]  speed_lo;
    logic [7:0]  speed_hi;
    logic [7:0]  palette_hi;

    int          line_len;
    t_phase      phase;
    logic [7:0]  type_chars [3];
    int          type_count;
    int          magnitude;
    logic        minus;

    logic [7:0]  c1_val;
    logic [7:0]  c2_val;
    logic [7:0]  c3_val;
    logic [7:0]  ix_val;
    logic [7:0]  sx_val;
    logic [7:0]  pal_val;
    logic        strobe_running;
    logic        strobe_bright;
    int          strobe_ticks;

    function automatic logic blank_char(logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
    endfunction

    function automatic int bound(int x, int lo, int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // unused tail positions compare as zero bytes
    function automatic t_token lookup_type();
        logic [23:0] word;
        if (type_count < 1 || type_count > 3) return TK_NONE;
        word = {type_chars[0], (type_count > 1) ? type_chars[1] : 8'h00,
                (type_count > 2) ? type_chars[2] : 8'h00};
        case (word)
            {"P", 16'h0000}: return TK_P;
            "PWR":           return TK_PWR;
            "STB":           return TK_STB;
            "PAL":           return TK_PAL;
            "C1D":           return TK_C1D;
            "C2D":           return TK_C2D;
            "C3D":           return TK_C3D;
            "IXD":           return TK_IXD;
            "SXD":           return TK_SXD;
            {"C1", 8'h00}:   return TK_C1;
            {"C2", 8'h00}:   return TK_C2;
            {"C3", 8'h00}:   return TK_C3;
            {"IX", 8'h00}:   return TK_IX;
            {"SX", 8'h00}:   return TK_SX;
            default:         return TK_NONE;
        endcase
    endfunction

    function automatic logic [7:0] param_now(t_action act);
        case (act)
            ACT_CUSTOM_ONE:   return c1_val;
            ACT_CUSTOM_TWO:   return c2_val;
            ACT_CUSTOM_THREE: return c3_val;
            ACT_INTENSITY:    return ix_val;
            ACT_SPEED:        return sx_val;
            default:          return pal_val;
        endcase
    endfunction

    task automatic report(t_action act, logic [7:0] value, logic [15:0] trans);
        t_led_action item;
        item.act = act;
        item.value = value;
        item.trans = trans;
        expected_actions.push_back(item);
    endtask

    // only a change is reported
    task automatic change_param(t_action act, int target);
        if (target == int'(param_now(act))) return;
        case (act)
            ACT_CUSTOM_ONE:   c1_val = 8'(target);
            ACT_CUSTOM_TWO:   c2_val = 8'(target);
            ACT_CUSTOM_THREE: c3_val = 8'(target);
            ACT_INTENSITY:    ix_val = 8'(target);
            ACT_SPEED:        sx_val = 8'(target);
            default:          pal_val = 8'(target);
        endcase
        report(act, 8'(target), 16'd0);
    endtask

    task automatic clear_line();
        line_len = 0;
        phase = PH_LEAD;
        type_count = 0;
        magnitude = 0;
        minus = 1'b0;
    endtask

    task automatic reset_model();
        normal_trans = RST_NORMAL_TRANSITION;
        instant_lo = RST_INSTANT_LOW;
        instant_hi = RST_INSTANT_HIGH;
        strobe_period = RST_STROBE_INTERVAL;
        speed_lo = RST_SPEED_MIN;
        speed_hi = RST_SPEED_MAX;
        palette_hi = RST_PALETTE_MAX;
        clear_line();
        c1_val = RST_CUSTOM_ONE;
        c2_val = RST_CUSTOM_TWO;
        c3_val = 8'(RST_CUSTOM_THREE);
        ix_val = RST_INTENSITY;
        sx_val = RST_SPEED;
        pal_val = RST_PALETTE;
        strobe_running = 1'b0;
        strobe_bright = 1'b1;
        strobe_ticks = 0;
    endtask

    task automatic add_type_char(logic [7:0] c);
        logic [7:0] up;
        up = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_SHIFT : c;
        if (type_count < 3) type_chars[type_count] = up;
        if (type_count < 4) type_count++;
    endtask

    task automatic take_char(logic [7:0] c);
        logic digit;
        digit = c >= CHAR_ZERO && c <= CHAR_NINE;
        case (phase)
            PH_LEAD: begin
                if (c == CHAR_COLON) begin
                    phase = PH_DEAD;
                end else if (!blank_char(c)) begin
                    add_type_char(c);
                    phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (c == CHAR_COLON) phase = PH_VBLANK;
                else add_type_char(c);
            end
            PH_VBLANK: begin
                if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    minus = c == CHAR_MINUS;
                    phase = PH_VSIGN;
                end else if (digit) begin
                    magnitude = int'(c) - int'(CHAR_ZERO);
                    phase = PH_VDIGIT;
                end else if (!blank_char(c)) begin
                    phase = PH_VEND;
                end
            end
            PH_VSIGN, PH_VDIGIT: begin
                if (digit) begin
                    magnitude = magnitude * 10 + int'(c) - int'(CHAR_ZERO);
                    if (magnitude > 65535) magnitude = 65535;
                    phase = PH_VDIGIT;
                end else begin
                    phase = PH_VEND;
                end
            end
            default: ;
        endcase
    endtask

    task automatic run_line();
        t_token  tk;
        t_action act;
        int      v;
        int      lo;
        int      hi;
        int      base;
        if (phase == PH_LEAD || phase == PH_TYPE || phase == PH_DEAD) return;
        tk = lookup_type();
        if (tk == TK_NONE) return;
        v = minus ? -magnitude : magnitude;
        case (tk)
            TK_P: begin
                if (v >= 1 && v <= PRESET_MAX) begin
                    report(ACT_PRESET, 8'(v),
                           (v >= int'(instant_lo) && v <= int'(instant_hi)) ? 16'd0
                                                                           : normal_trans);
                end
            end
            TK_PWR: report(ACT_POWER, 8'd0, 16'd0);
            TK_STB: begin
                if (v == 1) begin
                    if (!strobe_running) begin
                        strobe_running = 1'b1;
                        strobe_bright = 1'b1;
                        strobe_ticks = 0;
                        report(ACT_STROBE_BRIGHT, 8'd0, 16'd0);
                    end
                end else if (strobe_running) begin
                    strobe_running = 1'b0;
                    report(ACT_STROBE_BRIGHT, 8'd0, 16'd0);
                end
            end
            TK_PAL: change_param(ACT_PALETTE, bound(v, 0, int'(palette_hi)));
            default: begin
                lo = 0;
                hi = int'(PARAM_MAX);
                case (tk)
                    TK_C1D, TK_C1: act = ACT_CUSTOM_ONE;
                    TK_C2D, TK_C2: act = ACT_CUSTOM_TWO;
                    TK_C3D, TK_C3: begin
                        act = ACT_CUSTOM_THREE;
                        hi = int'(CUSTOM_THREE_MAX);
                    end
                    TK_IXD, TK_IX: act = ACT_INTENSITY;
                    default: begin
                        act = ACT_SPEED;
                        lo = int'(speed_lo);
                        hi = int'(speed_hi);
                    end
                endcase
                // delta forms add to the current value
                base = (tk <= TK_SXD) ? int'(param_now(act)) : 0;
                change_param(act, bound(base + v, lo, hi));
            end
        endcase
    endtask

    task automatic apply_beat(logic tick, logic [7:0] c);
        if (tick) begin
            if (strobe_running) begin
                if (strobe_ticks < 65535) strobe_ticks++;
                if (strobe_ticks >= int'(strobe_period)) begin
                    strobe_ticks = 0;
                    strobe_bright = !strobe_bright;
                    report(strobe_bright ? ACT_STROBE_BRIGHT : ACT_STROBE_DARK, 8'd0, 16'd0);
                end
            end
        end else if (c == CHAR_LF) begin
            if (line_len != 0) begin
                run_line();
                clear_line();
            end
        end else if (c != CHAR_CR) begin
            if (line_len < LCL_MAX_LINE) begin
                line_len++;
                take_char(c);
            end else begin
                clear_line();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_led_action want;
        if (!i_rst_n) begin
            reset_model();
            expected_actions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NORMAL_TRANSITION: normal_trans = i_cfg_data;
                    CFG_INSTANT_LOW:       instant_lo = i_cfg_data[7:0];
                    CFG_INSTANT_HIGH:      instant_hi = i_cfg_data[7:0];
                    CFG_STROBE_INTERVAL:   strobe_period = i_cfg_data;
                    CFG_SPEED_MIN:         speed_lo = i_cfg_data[7:0];
                    CFG_SPEED_MAX:         speed_hi = i_cfg_data[7:0];
                    CFG_PALETTE_MAX:       palette_hi = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) apply_beat(i_tick, i_data_byte);
            if (i_out_valid && i_out_ready) begin
                if (expected_actions.size() == 0) begin
                    $error("unexpected result beat: action %0d value %0d transition %0d",
                           i_action, i_action_value, i_transition_ms);
                    o_fails++;
                end else begin
                    want = expected_actions.pop_front();
                    if (i_action !== want.act) begin
                        $error("action: expected %0d, got %0d", want.act, i_action);
                        o_fails++;
                    end
                    if (i_action_value !== want.value) begin
                        $error("action_value: expected %0d, got %0d", want.value,
                               i_action_value);
                        o_fails++;
                    end
                    if (i_transition_ms !== want.trans) begin
                        $error("transition_ms: expected %0d, got %0d", want.trans,
                               i_transition_ms);
                        o_fails++;
                    end
                end
            end
        end
        o_pending = expected_actions.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import led_cli_pkg::*;

    localparam int   CYCLE_LIMIT = 500000;
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_action;
    logic [7:0]  o_action_value;
    logic [15:0] o_transition_ms;

    int pending;
    int fails;
    int cycles;
    int items;
    int send_calm;
    int take_calm;

    logic [7:0] line_buf[$];

    string token_words[14] = '{"P", "PWR", "STB", "PAL", "C1D", "C2D", "C3D", "IXD", "SXD",
                               "C1", "C2", "C3", "IX", "SX"};
    string odd_words[4] = '{"Q", "PW", "C4", "SXDX"};

    led_command_line_interpreter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_action        (o_action),
        .o_action_value  (o_action_value),
        .o_transition_ms (o_transition_ms)
    );

    led_cli_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_tick          (i_command),
        .i_data_byte     (i_data_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_action        (o_action),
        .i_action_value  (o_action_value),
        .i_transition_ms (o_transition_ms),
        .o_pending       (pending),
        .o_fails         (fails)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("led_command_line_interpreter: mismatch");
            $finish;
        end
    end

    // idle stretches alternate with runs of back-to-back beats
    function automatic int pause_len(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = pause_len(take_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic send_beat(logic cmd, logic [7:0] b);
        int gap;
        gap = pause_len(send_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items++;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_beat(CMD_BYTE, s[k]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        send_beat(CMD_BYTE, CHAR_LF);
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [15:0] trans, logic [7:0] lo, logic [7:0] hi,
                             logic [15:0] period, logic [7:0] smin, logic [7:0] smax,
                             logic [7:0] pmax);
        drain();
        write_reg(CFG_NORMAL_TRANSITION, trans);
        write_reg(CFG_INSTANT_LOW, 16'(lo));
        write_reg(CFG_INSTANT_HIGH, 16'(hi));
        write_reg(CFG_STROBE_INTERVAL, period);
        write_reg(CFG_SPEED_MIN, 16'(smin));
        write_reg(CFG_SPEED_MAX, 16'(smax));
        write_reg(CFG_PALETTE_MAX, 16'(pmax));
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    task automatic put_text(string s);
        for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    endtask

    task automatic put_word(string w);
        logic [7:0] c;
        for (int k = 0; k < w.len(); k++) begin
            c = w[k];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + CASE_SHIFT;
            line_buf.push_back(c);
        end
    endtask

    task automatic put_value();
        int mag;
        case ($urandom_range(0, 9))
            0: ;
            1: line_buf.push_back(8'($urandom_range("a", "z")));
            2: line_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            3: put_text("9999999");
            default: begin
                case ($urandom_range(0, 2))
                    0: line_buf.push_back(CHAR_PLUS);
                    1: line_buf.push_back(CHAR_MINUS);
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0:       mag = $urandom_range(0, 9);
                    1:       mag = $urandom_range(0, 300);
                    2:       mag = $urandom_range(240, 260);
                    default: mag = $urandom_range(0, 65535);
                endcase
                if ($urandom_range(0, 7) == 0) line_buf.push_back(CHAR_ZERO);
                put_text($sformatf("%0d", mag));
            end
        endcase
    endtask

    task automatic send_buf();
        while (line_buf.size() != 0) send_beat(CMD_BYTE, line_buf.pop_front());
    endtask

    task automatic random_line();
        int pick;
        line_buf.delete();
        if ($urandom_range(0, 3) == 0) line_buf.push_back(random_blank());
        pick = $urandom_range(0, 17);
        if (pick < 14) put_word(token_words[pick]);
        else put_word(odd_words[pick - 14]);
        if ($urandom_range(0, 15) == 0) line_buf.push_back(random_blank());
        if ($urandom_range(0, 15) != 0) line_buf.push_back(CHAR_COLON);
        if ($urandom_range(0, 3) == 0) line_buf.push_back(random_blank());
        if (pick == int'(TK_STB) && $urandom_range(0, 1) == 1) put_text("1");
        else put_value();
        if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
        send_buf();
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 8)) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) send_beat(CMD_BYTE, CHAR_LF);
    endtask

    task automatic overlong_line();
        logic [7:0] c;
        repeat ($urandom_range(31, 45)) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_LF) c = "x";
            send_beat(CMD_BYTE, c);
        end
        random_line();
    endtask

    task automatic random_phase(int beats);
        int stop_at;
        stop_at = items + beats;
        while (items < stop_at) begin
            case ($urandom_range(0, 19))
                0:          noise_burst();
                1:          overlong_line();
                2, 3, 4, 5: repeat ($urandom_range(1, 12)) send_tick();
                default:    random_line();
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_NORMAL_TRANSITION;
        i_cfg_data = 16'd0;
        i_valid = 1'b0;
        i_command = CMD_BYTE;
        i_data_byte = 8'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_line("P:1");
        send_line("p:250");
        send_line("P:251");
        send_line("P:0");
        send_line("P:10");
        send_line("pwr:whatever");
        send_line("STB:1");
        send_line("stb:1");
        repeat (3) send_tick();
        send_line("STB:0");
        send_line("STB:7");
        repeat (2) send_tick();
        send_line("C1:300");
        send_line("c1d:-1000");
        send_line("C2: \t+7");
        send_line("C3:99");
        send_line("C3D:-3");
        send_line("IX:128");
        send_line("ixd:1");
        send_line("SX:0");
        send_line("SXD:999999999");
        send_line("PAL:-5");
        send_line("Pal:300");
        send_line("  C1 :5");
        send_line(":5");
        send_line("C1");
        send_line("C1:+");
        send_line("C1:-");
        send_line("C1:12ab");
        send_beat(CMD_BYTE, CHAR_LF);
        send_text("P:");
        send_beat(CMD_BYTE, CHAR_CR);
        send_line("7");
        repeat (26) send_beat(CMD_BYTE, CHAR_SPACE);
        send_line("C1:77");
        repeat (32) send_beat(CMD_BYTE, "x");
        send_line("P:3");
        send_text("P");
        send_beat(CMD_BYTE, 8'h00);
        send_line(":4");
        send_text("C2:5");
        send_beat(CMD_BYTE, 8'hFF);
        send_beat(CMD_BYTE, CHAR_LF);

        configure(16'd0, 8'd1, 8'd250, 16'd1, 8'd0, 8'd255, 8'd255);
        random_phase(90);
        configure(16'd65535, 8'd250, 8'd1, 16'd2, 8'd255, 8'd0, 8'd0);
        random_phase(90);
        configure(16'd1500, 8'd5, 8'd20, 16'd0, 8'd100, 8'd50, 8'd10);
        random_phase(90);
        configure(16'd700, 8'd9, 8'd12, 16'd65535, 8'd64, 8'd191, 8'd71);
        random_phase(90);
        configure(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 250)),
                  8'($urandom_range(1, 250)), 16'($urandom_range(1, 6)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        random_phase(90);
        configure(16'd300, 8'd100, 8'd100, 16'd3, 8'd0, 8'd0, 8'd255);
        random_phase(90);

        drain();
        if (fails == 0) begin
            $display("led_command_line_interpreter: match");
        end else begin
            $display("led_command_line_interpreter: mismatch");
        end
        $finish;
    end

endmodule
